/* sv/psp_pkg.sv */
// Shared types, codes and helpers for the PSI section parser.
`timescale 1ns / 1ps
package psp_pkg;

	// Result kinds
	localparam logic [1:0] EntProg   = 2'd0;
	localparam logic [1:0] EntEs     = 2'd1;
	localparam logic [1:0] EntStatus = 2'd2;

	// Section status codes
	localparam logic [1:0] StOk    = 2'd0;
	localparam logic [1:0] StBadId = 2'd1;
	localparam logic [1:0] StShort = 2'd2;
	localparam logic [1:0] StNoEs  = 2'd3;

	// Stream classes
	localparam logic [1:0] ClsOther = 2'd0;
	localparam logic [1:0] ClsVideo = 2'd1;
	localparam logic [1:0] ClsAudio = 2'd2;

	// Table ids and stream type codes
	localparam logic [7:0] TidPat      = 8'h00;
	localparam logic [7:0] TidPmt      = 8'h02;
	localparam logic [7:0] TypeMpeg2V  = 8'h02;
	localparam logic [7:0] TypeAvc     = 8'h1b;
	localparam logic [7:0] TypeMpeg2A  = 8'h04;
	localparam logic [7:0] TypeAac     = 8'h0f;

	// Byte offset saturation point
	localparam logic [12:0] OffsetMax = 13'h1fff;

	// Command queue depth between front and back
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	// One queued command: an optional entry result followed by an optional status
	typedef struct packed {
		logic        ent_v;
		logic [1:0]  ent_kind;
		logic [15:0] ent_pn;
		logic [12:0] ent_pid;
		logic [7:0]  ent_type;
		logic        st_v;
		logic [15:0] st_pn;
		logic [1:0]  st_code;
	} cmd_t;

	// Classify an elementary stream type byte
	function automatic logic [1:0] class_of(input logic [7:0] t);
		logic [1:0] c;
		c = ClsOther;
		if (t == TypeMpeg2V || t == TypeAvc) c = ClsVideo;
		else if (t == TypeMpeg2A || t == TypeAac) c = ClsAudio;
		return c;
	endfunction

endpackage

/* sv/psp_in_if.sv */
// Section byte channel: valid/ready handshake with one byte and its marks.
`timescale 1ns / 1ps
interface psp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;
	logic       table_kind;

	modport source (output valid, data_byte, first_byte, last_byte, table_kind, input ready);
	modport sink   (input valid, data_byte, first_byte, last_byte, table_kind, output ready);
endinterface

/* sv/psp_out_if.sv */
// Parse result channel: valid/ready handshake with one result.
`timescale 1ns / 1ps
interface psp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  entry_kind;
	logic [15:0] program_number;
	logic [12:0] stream_pid;
	logic [7:0]  es_type;
	logic [1:0]  stream_class;
	logic        network_entry;
	logic [1:0]  status;
	logic        last_result;

	modport source (output valid, entry_kind, program_number, stream_pid, es_type,
		stream_class, network_entry, status, last_result, input ready);
	modport sink   (input valid, entry_kind, program_number, stream_pid, es_type,
		stream_class, network_entry, status, last_result, output ready);
endinterface

/* sv/psi_section_parser_unit.sv */
// PAT/PMT section parser: byte-per-cycle front end, command queue, result stage.
// Each result passes through the command queue and the registered output stage.
// Throughput: one byte per cycle while the queue has room; results leave at one per
// cycle through the output register while the sink is ready, so a byte that both closes
// an entry and ends the section gives two results, the entry and then its status.
// Input is held off only while the four-deep command queue is full.
// Reset (arst_n low) clears all section state, the queue pointers and the output valid.
`timescale 1ns / 1ps
module psi_section_parser_unit (
	input  logic      clk,
	input  logic      arst_n,
	psp_in_if.sink    sec,
	psp_out_if.source res
);
	import psp_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic full;
	logic head_v;

	psp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sec      (sec),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	psp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.head_v   (head_v),
		.head     (head)
	);

	psp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head_v (head_v),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

/* sv/psp_front.sv */
// Front end: accepts section bytes, tracks section state and queues result commands.
`timescale 1ns / 1ps
module psp_front (
	input  logic         clk,
	input  logic         arst_n,
	psp_in_if.sink       sec,
	input  logic         full,
	output logic         push,
	output psp_pkg::cmd_t push_cmd
);
	import psp_pkg::*;

	logic [12:0] off_q, n_off, o;
	logic [11:0] slen_q, n_slen;
	logic [11:0] ilen_q, n_ilen;
	logic [15:0] sid_q, n_sid;
	logic [39:0] eb_q, n_eb, shifted;
	logic [2:0]  idx_q, n_idx;
	logic [11:0] skip_q, n_skip;
	logic        kind_q, n_kind;
	logic        err_q, n_err;
	logic        es_q, n_es;
	logic        accept;
	logic        in_body;
	logic [13:0] size;
	logic [1:0]  st_code;
	logic        ent_v;
	logic [1:0]  ent_kind;
	logic [15:0] ent_pn;
	logic [12:0] ent_pid;
	logic [7:0]  ent_type;

	assign sec.ready = !full;
	assign accept    = sec.valid && sec.ready;

	// Work out next section state and the results of this byte
	always_comb begin
		o       = sec.first_byte ? 13'd0 : off_q;
		shifted = {eb_q[31:0], sec.data_byte};
		n_slen  = slen_q;
		n_ilen  = ilen_q;
		n_sid   = sid_q;
		n_eb    = eb_q;
		n_idx   = idx_q;
		n_skip  = skip_q;
		n_kind  = kind_q;
		n_err   = err_q;
		n_es    = es_q;
		ent_v    = 1'b0;
		ent_kind = EntProg;
		ent_pn   = '0;
		ent_pid  = '0;
		ent_type = '0;

		// Header fields
		if (o == 13'd0) begin
			n_slen = '0;
			n_ilen = '0;
			n_sid  = '0;
			n_eb   = '0;
			n_idx  = '0;
			n_skip = '0;
			n_es   = 1'b0;
			n_kind = sec.table_kind;
			n_err  = sec.data_byte != (sec.table_kind ? TidPmt : TidPat);
		end else if (o == 13'd1) begin
			n_slen = {sec.data_byte[3:0], 8'h00};
		end else if (o == 13'd2) begin
			n_slen = {slen_q[11:8], sec.data_byte};
		end else if (o == 13'd3) begin
			n_sid = {sec.data_byte, 8'h00};
		end else if (o == 13'd4) begin
			n_sid = {sid_q[15:8], sec.data_byte};
		end else if (kind_q && o == 13'd10) begin
			n_ilen = {sec.data_byte[3:0], 8'h00};
		end else if (kind_q && o == 13'd11) begin
			n_ilen = {ilen_q[11:8], sec.data_byte};
			n_skip = {ilen_q[11:8], sec.data_byte};
			n_idx  = '0;
		end

		// Entry loop, up to the CRC
		in_body = !err_q && (o >= 13'd8) && (({1'b0, o} + 14'd1) < {2'b00, slen_q});
		if (in_body && !kind_q) begin
			n_eb = shifted;
			if (idx_q >= 3'd3) begin
				ent_v    = 1'b1;
				ent_kind = EntProg;
				ent_pn   = shifted[31:16];
				ent_pid  = shifted[12:0];
				n_idx    = '0;
			end else begin
				n_idx = idx_q + 3'd1;
			end
		end else if (in_body && kind_q && o >= 13'd12) begin
			if (skip_q != 12'd0) begin
				n_skip = skip_q - 12'd1;
			end else begin
				n_eb = shifted;
				if (idx_q >= 3'd4) begin
					ent_v    = 1'b1;
					ent_kind = EntEs;
					ent_pn   = sid_q;
					ent_pid  = shifted[28:16];
					ent_type = shifted[39:32];
					n_skip   = shifted[11:0];
					n_idx    = '0;
					n_es     = 1'b1;
				end else begin
					n_idx = idx_q + 3'd1;
				end
			end
		end

		// Closing status from the updated state
		size = {1'b0, o} + 14'd1;
		if (!n_kind) begin
			priority if (size <= 14'd8)                   st_code = StShort;
			else if (n_err)                               st_code = StBadId;
			else if ({2'b00, n_slen} > size - 14'd3)      st_code = StShort;
			else if (n_slen < 12'd9)                      st_code = StShort;
			else                                          st_code = StOk;
		end else begin
			priority if (size <= 14'd12)                  st_code = StShort;
			else if (n_err)                               st_code = StBadId;
			else if ({2'b00, n_slen} > size - 14'd3)      st_code = StShort;
			else if (n_slen <= 12'd13)                    st_code = StShort;
			else if (n_slen - 12'd13 <= n_ilen)           st_code = StNoEs;
			else if (!n_es)                               st_code = StNoEs;
			else                                          st_code = StOk;
		end

		push_cmd.ent_v    = ent_v;
		push_cmd.ent_kind = ent_kind;
		push_cmd.ent_pn   = ent_pn;
		push_cmd.ent_pid  = ent_pid;
		push_cmd.ent_type = ent_type;
		push_cmd.st_v     = sec.last_byte;
		push_cmd.st_pn    = n_kind ? n_sid : 16'd0;
		push_cmd.st_code  = st_code;

		// Advance offset, or drop the section after its last byte
		if (sec.last_byte) begin
			n_off  = '0;
			n_slen = '0;
			n_ilen = '0;
			n_sid  = '0;
			n_eb   = '0;
			n_idx  = '0;
			n_skip = '0;
			n_kind = 1'b0;
			n_err  = 1'b0;
			n_es   = 1'b0;
		end else begin
			n_off = (o < OffsetMax) ? o + 13'd1 : OffsetMax;
		end
	end

	assign push = accept && (ent_v || sec.last_byte);

	// Section state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			slen_q <= '0;
			ilen_q <= '0;
			sid_q  <= '0;
			eb_q   <= '0;
			idx_q  <= '0;
			skip_q <= '0;
			kind_q <= 1'b0;
			err_q  <= 1'b0;
			es_q   <= 1'b0;
		end else if (accept) begin
			off_q  <= n_off;
			slen_q <= n_slen;
			ilen_q <= n_ilen;
			sid_q  <= n_sid;
			eb_q   <= n_eb;
			idx_q  <= n_idx;
			skip_q <= n_skip;
			kind_q <= n_kind;
			err_q  <= n_err;
			es_q   <= n_es;
		end
	end

endmodule

/* sv/psp_queue.sv */
// Short command queue between the front end and the result stage.
`timescale 1ns / 1ps
module psp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  psp_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_v,
	output psp_pkg::cmd_t head
);
	import psp_pkg::*;

	cmd_t           mem_q [QDepth];
	logic [QAw-1:0] wr_q;
	logic [QAw-1:0] rd_q;
	logic [QAw:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = cnt_q == (QAw+1)'(QDepth);
	assign head_v  = cnt_q != '0;
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && head_v;

	// Store commands
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == QAw'(QDepth - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == QAw'(QDepth - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* sv/psp_back.sv */
// Result stage: expands queued commands into results and holds them for the sink.
`timescale 1ns / 1ps
module psp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_v,
	input  psp_pkg::cmd_t head,
	output logic          pop,
	psp_out_if.source     res
);
	import psp_pkg::*;

	logic        phase_q;
	logic        ov_q;
	logic        sel_st;
	logic        load;
	logic [1:0]  kind_q;
	logic [15:0] pn_q;
	logic [12:0] pid_q;
	logic [7:0]  type_q;
	logic [1:0]  cls_q;
	logic        net_q;
	logic [1:0]  st_q;
	logic        last_q;

	assign sel_st = phase_q || !head.ent_v;
	assign load   = head_v && (!ov_q || res.ready);
	assign pop    = load && (sel_st || !head.st_v);

	// Output handshake and command phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load)           ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
			if (load)           phase_q <= !pop;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (sel_st) begin
				kind_q <= EntStatus;
				pn_q   <= head.st_pn;
				pid_q  <= '0;
				type_q <= '0;
				cls_q  <= ClsOther;
				net_q  <= 1'b0;
				st_q   <= head.st_code;
				last_q <= 1'b1;
			end else begin
				kind_q <= head.ent_kind;
				pn_q   <= head.ent_pn;
				pid_q  <= head.ent_pid;
				type_q <= head.ent_type;
				cls_q  <= (head.ent_kind == EntEs) ? class_of(head.ent_type) : ClsOther;
				net_q  <= (head.ent_kind == EntProg) && (head.ent_pn == 16'd0);
				st_q   <= StOk;
				last_q <= 1'b0;
			end
		end
	end

	assign res.valid          = ov_q;
	assign res.entry_kind     = kind_q;
	assign res.program_number = pn_q;
	assign res.stream_pid     = pid_q;
	assign res.es_type        = type_q;
	assign res.stream_class   = cls_q;
	assign res.network_entry  = net_q;
	assign res.status         = st_q;
	assign res.last_result    = last_q;

endmodule

/* sv/psp_checker.sv */
// Port-level assertions for the section parser, bound to the top level.
`timescale 1ns / 1ps
module psp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  entry_kind,
	input logic [15:0] program_number,
	input logic [12:0] stream_pid,
	input logic [7:0]  es_type,
	input logic [1:0]  stream_class,
	input logic        network_entry,
	input logic [1:0]  status,
	input logic        last_result
);
	import psp_pkg::*;

	// Status results and only they close a section
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last_result == (entry_kind == EntStatus)))
		else $error("last_result does not match a status result");

	// Entry results carry ok status
	a_entry_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && entry_kind != EntStatus |-> status == StOk)
		else $error("entry result with nonzero status");

	// Network flag only on program entries with program number zero
	a_network_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid && network_entry |-> entry_kind == EntProg && program_number == 16'd0)
		else $error("network_entry on a wrong result");

	// Video stream types are classed as video
	a_video_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid && entry_kind == EntEs && (es_type == TypeMpeg2V || es_type == TypeAvc)
		|-> stream_class == ClsVideo)
		else $error("video stream type not classed as video");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(entry_kind) && $stable(program_number)
		&& $stable(stream_pid) && $stable(status))
		else $error("stalled result changed");

endmodule

bind psi_section_parser_unit psp_checker u_psp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (res.valid),
	.ready          (res.ready),
	.entry_kind     (res.entry_kind),
	.program_number (res.program_number),
	.stream_pid     (res.stream_pid),
	.es_type        (res.es_type),
	.stream_class   (res.stream_class),
	.network_entry  (res.network_entry),
	.status         (res.status),
	.last_result    (res.last_result)
);
